// ===== src/gzhp_pkg.sv =====
// ----------------------------------------------------------------------------
// gzhp_pkg
// Shared types and constants for the gzip member header parser.
// ----------------------------------------------------------------------------
package gzhp_pkg;

  localparam int unsigned PREAMBLE_BYTES_DEFAULT = 128;

  localparam int unsigned SKIP_W  = 16;
  localparam int unsigned COUNT_W = 32;

  localparam logic [7:0] MAGIC_ID1   = 8'h1f;
  localparam logic [7:0] MAGIC_ID2   = 8'h8b;
  localparam logic [7:0] METHOD_DEFL = 8'h08;

  // flag_bits holds FLG >> 1
  localparam int unsigned FB_PART  = 0;
  localparam int unsigned FB_EXTRA = 1;
  localparam int unsigned FB_NAME  = 2;
  localparam int unsigned FB_COMM  = 3;
  localparam int unsigned FB_ENC   = 4;

  typedef enum logic [2:0] {
    ST_BUSY   = 3'd0,
    ST_DONE   = 3'd1,
    ST_MAGIC  = 3'd2,
    ST_METHOD = 3'd3,
    ST_ENC    = 3'd4,
    ST_TRUNC  = 3'd5,
    ST_IDLE   = 3'd6
  } status_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_flag;
    logic       end_flag;
  } item_t;

  typedef struct packed {
    status_t              status;
    logic [COUNT_W-1:0]   header_length;
  } result_t;

endpackage

// ===== src/gzip_header_parser_core.sv =====
// ----------------------------------------------------------------------------
// gzip_header_parser_core
// Byte-wide gzip member header parser with registered input and result.
// ----------------------------------------------------------------------------
//
//  channel  signals                                  direction
//  -------  ---------------------------------------  ---------
//  in       in_valid, in_stall, data_byte,           sink
//           start_flag, end_flag
//  out      out_valid, out_stall, status,            source
//           header_length
//
// one request per cycle sustained while out_stall stays low; each result leaves
// through the input register, then the result register, after its request is taken
// the parse state updates in the same cycle a result is registered, so
// consecutive bytes follow without bubbles
// synchronous reset clears the parse state and both valid flags
// out_stall holds the result register, and in_stall rises once the input
// register is also full
module gzip_header_parser_core
  import gzhp_pkg::*;
#(
  parameter int unsigned PREAMBLE_BYTES = PREAMBLE_BYTES_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         data_byte,
  input  logic               start_flag,
  input  logic               end_flag,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         status,
  output logic [COUNT_W-1:0] header_length
);

  item_t   s1_item;
  logic    s1_valid;
  logic    out_free;
  logic    step;
  result_t res;

  assign out_free = !out_valid || !out_stall;
  assign step     = s1_valid && out_free;
  assign in_stall = s1_valid && !out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_item.data_byte  <= data_byte;
      s1_item.start_flag <= start_flag;
      s1_item.end_flag   <= end_flag;
    end
  end

  gzhp_parser #(
    .PREAMBLE_BYTES(PREAMBLE_BYTES)
  ) u_parser (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .item   (s1_item),
    .result (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      status        <= res.status;
      header_length <= res.header_length;
    end
  end

endmodule

// ===== src/gzhp_parser.sv =====
// ----------------------------------------------------------------------------
// gzhp_parser
// Header parse state and the per-byte next-state logic. Presents the result
// for the current request; state advances when step is high.
// ----------------------------------------------------------------------------
module gzhp_parser
  import gzhp_pkg::*;
#(
  parameter int unsigned PREAMBLE_BYTES = PREAMBLE_BYTES_DEFAULT
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    step,
  input  item_t   item,
  output result_t result
);

  localparam logic [SKIP_W-1:0] PRE_SKIP = SKIP_W'(PREAMBLE_BYTES - 1);

  typedef enum logic [3:0] {
    PH_IDLE, PH_FIRST, PH_PREAMBLE, PH_MAGIC1, PH_MAGIC2, PH_METHOD, PH_FLAGS,
    PH_FIXED, PH_PART, PH_XLO, PH_XHI, PH_XDATA, PH_NAME, PH_COMMENT
  } phase_t;

  phase_t              phase, phase_next;
  logic [SKIP_W-1:0]   skip_count, skip_count_next;
  logic [4:0]          flag_bits, flag_bits_next;
  logic [7:0]          extra_len_low, extra_len_low_next;
  logic [COUNT_W-1:0]  byte_count, byte_count_next;

  // start-adjusted current state
  phase_t              ph;
  logic [SKIP_W-1:0]   sk;
  logic [4:0]          fb;
  logic [7:0]          xl;
  logic [COUNT_W-1:0]  bc;

  // choice of the next optional part
  phase_t              np_phase;
  logic [4:0]          np_flags;
  logic                np_done;

  status_t             st;
  logic [SKIP_W-1:0]   sk_dec;
  logic [SKIP_W-1:0]   xlen;

  always_comb begin
    ph = phase;
    sk = skip_count;
    fb = flag_bits;
    xl = extra_len_low;
    bc = byte_count;
    if (item.start_flag) begin
      ph = PH_FIRST;
      sk = '0;
      fb = '0;
      xl = '0;
      bc = '0;
    end
  end

  always_comb begin
    np_phase = ph;
    np_flags = fb;
    np_done  = 1'b0;
    priority if (fb[FB_PART]) begin
      np_flags[FB_PART] = 1'b0;
      np_phase = PH_PART;
    end else if (fb[FB_EXTRA]) begin
      np_flags[FB_EXTRA] = 1'b0;
      np_phase = PH_XLO;
    end else if (fb[FB_NAME]) begin
      np_flags[FB_NAME] = 1'b0;
      np_phase = PH_NAME;
    end else if (fb[FB_COMM]) begin
      np_flags[FB_COMM] = 1'b0;
      np_phase = PH_COMMENT;
    end else begin
      np_done = 1'b1;
    end
  end

  assign sk_dec = sk - 1'b1;
  assign xlen   = {item.data_byte, xl};

  always_comb begin
    phase_next         = ph;
    skip_count_next    = sk;
    flag_bits_next     = fb;
    extra_len_low_next = xl;
    byte_count_next    = bc;
    st                 = ST_BUSY;
    if (ph == PH_IDLE) begin
      phase_next = PH_IDLE;
      st = ST_IDLE;
    end else if (item.end_flag) begin
      phase_next = PH_IDLE;
      st = ST_TRUNC;
    end else begin
      if (bc != '1) begin
        byte_count_next = bc + 1'b1;
      end
      unique case (ph)
        PH_FIRST: begin
          if (item.data_byte == 8'h00) begin
            skip_count_next = PRE_SKIP;
            phase_next = (PRE_SKIP == '0) ? PH_MAGIC1 : PH_PREAMBLE;
          end else if (item.data_byte != MAGIC_ID1) begin
            st = ST_MAGIC;
          end else begin
            phase_next = PH_MAGIC2;
          end
        end
        PH_PREAMBLE: begin
          skip_count_next = sk_dec;
          if (sk_dec == '0) begin
            phase_next = PH_MAGIC1;
          end
        end
        PH_MAGIC1: begin
          if (item.data_byte != MAGIC_ID1) st = ST_MAGIC;
          else phase_next = PH_MAGIC2;
        end
        PH_MAGIC2: begin
          if (item.data_byte != MAGIC_ID2) st = ST_MAGIC;
          else phase_next = PH_METHOD;
        end
        PH_METHOD: begin
          if (item.data_byte != METHOD_DEFL) st = ST_METHOD;
          else phase_next = PH_FLAGS;
        end
        PH_FLAGS: begin
          flag_bits_next = item.data_byte[5:1];
          if (item.data_byte[FB_ENC+1]) begin
            st = ST_ENC;
          end else begin
            skip_count_next = SKIP_W'(6);
            phase_next = PH_FIXED;
          end
        end
        PH_FIXED, PH_PART, PH_XDATA: begin
          skip_count_next = sk_dec;
          if (sk_dec == '0) begin
            if (np_done) begin
              st = ST_DONE;
            end else begin
              phase_next     = np_phase;
              flag_bits_next = np_flags;
              if (np_phase == PH_PART) skip_count_next = SKIP_W'(2);
            end
          end
        end
        PH_XLO: begin
          extra_len_low_next = item.data_byte;
          phase_next = PH_XHI;
        end
        PH_XHI: begin
          skip_count_next = xlen;
          if (xlen == '0) begin
            // empty extra field goes straight on
            if (np_done) begin
              st = ST_DONE;
            end else begin
              phase_next     = np_phase;
              flag_bits_next = np_flags;
              if (np_phase == PH_PART) skip_count_next = SKIP_W'(2);
            end
          end else begin
            phase_next = PH_XDATA;
          end
        end
        PH_NAME, PH_COMMENT: begin
          if (item.data_byte == 8'h00) begin
            if (np_done) begin
              st = ST_DONE;
            end else begin
              phase_next     = np_phase;
              flag_bits_next = np_flags;
              if (np_phase == PH_PART) skip_count_next = SKIP_W'(2);
            end
          end
        end
        default: begin
          st = ST_MAGIC;
        end
      endcase
      if (st != ST_BUSY) begin
        phase_next = PH_IDLE;
      end
    end
  end

  assign result.status        = st;
  assign result.header_length = byte_count_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      skip_count    <= '0;
      flag_bits     <= '0;
      extra_len_low <= '0;
      byte_count    <= '0;
    end else if (step) begin
      phase         <= phase_next;
      skip_count    <= skip_count_next;
      flag_bits     <= flag_bits_next;
      extra_len_low <= extra_len_low_next;
      byte_count    <= byte_count_next;
    end
  end

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for gzip_header_parser_core. Byte streams go in through
// the valid/stall request channel. A local parse model predicts status and
// header length for every accepted byte, and each result is compared as it
// leaves the block. The stimulus covers directed header cases, a preamble
// skip, random well-formed and broken headers, a long output hold and a
// sender pause.
// ----------------------------------------------------------------------------
module testbench
  import gzhp_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [3:0] {
    PH_IDLE, PH_FIRST, PH_PREAMBLE, PH_MAGIC1, PH_MAGIC2, PH_METHOD, PH_FLAGS,
    PH_FIXED, PH_PART, PH_XLO, PH_XHI, PH_XDATA, PH_NAME, PH_COMMENT
  } parse_phase_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [7:0]         data_byte = 8'h00;
  logic               start_flag = 1'b0;
  logic               end_flag = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [2:0]         status;
  logic [COUNT_W-1:0] header_length;

  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  int unsigned hold_len = 0;
  int unsigned hold_req = 0;
  int unsigned hold_ack = 0;
  int unsigned hold_left = 0;

  int unsigned fail_count = 0;
  int unsigned checked_count = 0;
  int unsigned done_count = 0;
  int unsigned reject_count = 0;
  int unsigned trunc_count = 0;

  // parse model state
  parse_phase_t       pm_phase;
  logic [SKIP_W-1:0]  pm_skip;
  logic [4:0]         pm_flags;
  logic [7:0]         pm_xlen_lo;
  logic [COUNT_W-1:0] pm_count;

  result_t header_status_q[$];

  gzip_header_parser_core DUT (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .data_byte     (data_byte),
    .start_flag    (start_flag),
    .end_flag      (end_flag),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .header_length (header_length)
  );

  always #10 clk = ~clk;

  // moves on to the next optional header part, or reports the header done
  function automatic status_t pick_next_part();
    if (pm_flags[FB_PART]) begin
      pm_flags[FB_PART] = 1'b0;
      pm_skip = SKIP_W'(2);
      pm_phase = PH_PART;
      return ST_BUSY;
    end
    if (pm_flags[FB_EXTRA]) begin
      pm_flags[FB_EXTRA] = 1'b0;
      pm_phase = PH_XLO;
      return ST_BUSY;
    end
    if (pm_flags[FB_NAME]) begin
      pm_flags[FB_NAME] = 1'b0;
      pm_phase = PH_NAME;
      return ST_BUSY;
    end
    if (pm_flags[FB_COMM]) begin
      pm_flags[FB_COMM] = 1'b0;
      pm_phase = PH_COMMENT;
      return ST_BUSY;
    end
    return ST_DONE;
  endfunction

  function automatic result_t predict_header_byte(input logic [7:0] b, input logic s,
                                                  input logic e);
    result_t res;
    status_t st;
    if (s) begin
      pm_phase = PH_FIRST;
      pm_skip = '0;
      pm_flags = '0;
      pm_xlen_lo = '0;
      pm_count = '0;
    end
    if (pm_phase == PH_IDLE) begin
      st = ST_IDLE;
    end else if (e) begin
      pm_phase = PH_IDLE;
      st = ST_TRUNC;
    end else begin
      if (pm_count != '1) pm_count = pm_count + 1'b1;
      st = ST_BUSY;
      case (pm_phase)
        PH_FIRST: begin
          if (b == 8'h00) begin
            pm_skip = SKIP_W'(PREAMBLE_BYTES_DEFAULT - 1);
            pm_phase = (pm_skip == 0) ? PH_MAGIC1 : PH_PREAMBLE;
          end else if (b != MAGIC_ID1) begin
            st = ST_MAGIC;
          end else begin
            pm_phase = PH_MAGIC2;
          end
        end
        PH_PREAMBLE: begin
          pm_skip = pm_skip - 1'b1;
          if (pm_skip == 0) pm_phase = PH_MAGIC1;
        end
        PH_MAGIC1: begin
          if (b != MAGIC_ID1) st = ST_MAGIC;
          else pm_phase = PH_MAGIC2;
        end
        PH_MAGIC2: begin
          if (b != MAGIC_ID2) st = ST_MAGIC;
          else pm_phase = PH_METHOD;
        end
        PH_METHOD: begin
          if (b != METHOD_DEFL) st = ST_METHOD;
          else pm_phase = PH_FLAGS;
        end
        PH_FLAGS: begin
          pm_flags = b[5:1];
          if (pm_flags[FB_ENC]) begin
            st = ST_ENC;
          end else begin
            pm_skip = SKIP_W'(6);
            pm_phase = PH_FIXED;
          end
        end
        PH_FIXED, PH_PART, PH_XDATA: begin
          pm_skip = pm_skip - 1'b1;
          if (pm_skip == 0) st = pick_next_part();
        end
        PH_XLO: begin
          pm_xlen_lo = b;
          pm_phase = PH_XHI;
        end
        PH_XHI: begin
          pm_skip = {b, pm_xlen_lo};
          if (pm_skip == 0) st = pick_next_part();
          else pm_phase = PH_XDATA;
        end
        PH_NAME, PH_COMMENT: begin
          if (b == 8'h00) st = pick_next_part();
        end
        default: st = ST_MAGIC;
      endcase
      if (st != ST_BUSY) pm_phase = PH_IDLE;
    end
    res.status = st;
    res.header_length = pm_count;
    return res;
  endfunction

  // result check first, then the prediction for a request taken at this edge
  always @(posedge clk) begin : scoreboard
    result_t want;
    if (rst) begin
      pm_phase = PH_IDLE;
      pm_skip = '0;
      pm_flags = '0;
      pm_xlen_lo = '0;
      pm_count = '0;
    end else begin
      if (out_valid && !out_stall) begin
        if (header_status_q.size() == 0) begin
          $error("unexpected result: status %0d, header_length %0d", status, header_length);
          fail_count++;
        end else begin
          want = header_status_q.pop_front();
          checked_count++;
          if (status !== want.status) begin
            $error("status mismatch: expected %0d, actual %0d", want.status, status);
            fail_count++;
          end
          if (header_length !== want.header_length) begin
            $error("header_length mismatch: expected %0d, actual %0d",
                   want.header_length, header_length);
            fail_count++;
          end
          case (want.status)
            ST_DONE: done_count++;
            ST_MAGIC, ST_METHOD, ST_ENC: reject_count++;
            ST_TRUNC: trunc_count++;
            default: ;
          endcase
        end
      end
      if (in_valid && !in_stall)
        header_status_q.push_back(predict_header_byte(data_byte, start_flag, end_flag));
    end
  end

  // receiver: random stall, or a counted hold when one is requested
  always @(posedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack <= hold_req;
      hold_left <= hold_len;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  task automatic send_item(input logic [7:0] b, input logic s, input logic e);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    start_flag <= s;
    end_flag <= e;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // sends bytes from..upto-1 of a stream; byte 0 carries the start flag
  task automatic send_stream(ref logic [7:0] q[$], input int unsigned from,
                             input int unsigned upto);
    for (int unsigned i = from; i < upto; i++) send_item(q[i], i == 0, 1'b0);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (header_status_q.size() != 0) @(posedge clk);
  endtask

  task automatic build_header(ref logic [7:0] q[$], input bit with_pre);
    logic [7:0] flg;
    int unsigned xlen;
    int unsigned n;
    q.delete();
    if (with_pre) begin
      q.push_back(8'h00);
      repeat (PREAMBLE_BYTES_DEFAULT - 1) q.push_back(8'($urandom));
    end
    q.push_back(MAGIC_ID1);
    q.push_back(MAGIC_ID2);
    q.push_back(METHOD_DEFL);
    flg = 8'($urandom);
    flg[FB_ENC + 1] = 1'b0;
    q.push_back(flg);
    repeat (6) q.push_back(8'($urandom));
    if (flg[FB_PART + 1]) repeat (2) q.push_back(8'($urandom));
    if (flg[FB_EXTRA + 1]) begin
      if ($urandom_range(39) == 0) xlen = $urandom_range(300, 256);
      else if ($urandom_range(6) == 0) xlen = 0;
      else xlen = $urandom_range(12);
      q.push_back(xlen[7:0]);
      q.push_back(xlen[15:8]);
      repeat (xlen) q.push_back(8'($urandom));
    end
    if (flg[FB_NAME + 1]) begin
      n = $urandom_range(6);
      repeat (n) q.push_back(8'($urandom_range(255, 1)));
      q.push_back(8'h00);
    end
    if (flg[FB_COMM + 1]) begin
      n = $urandom_range(6);
      repeat (n) q.push_back(8'($urandom_range(255, 1)));
      q.push_back(8'h00);
    end
  endtask

  task automatic test_idle_after_reset();
    send_item(8'hff, 1'b0, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);
  endtask

  task automatic test_header_errors();
    logic [7:0] hdr[$];
    hdr = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
    hdr[0] = MAGIC_ID1;
    hdr[1] = MAGIC_ID2;
    hdr[2] = METHOD_DEFL;
    send_stream(hdr, 0, hdr.size());
    // bytes after a finished header are ignored
    send_item(8'h1f, 1'b0, 1'b0);
    send_item(8'hff, 1'b1, 1'b0);
    hdr = '{MAGIC_ID1, 8'h00};
    send_stream(hdr, 0, hdr.size());
    hdr = '{MAGIC_ID1, MAGIC_ID2, 8'h07};
    send_stream(hdr, 0, hdr.size());
    hdr = '{MAGIC_ID1, MAGIC_ID2, METHOD_DEFL, 8'(1 << (FB_ENC + 1))};
    send_stream(hdr, 0, hdr.size());
    // empty extra field goes straight to done
    hdr = '{MAGIC_ID1, MAGIC_ID2, METHOD_DEFL, 8'(1 << (FB_EXTRA + 1)),
            8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'h00, 8'h00};
    send_stream(hdr, 0, hdr.size());
    send_item(8'h00, 1'b1, 1'b1);
    hdr = '{MAGIC_ID1, MAGIC_ID2};
    send_stream(hdr, 0, hdr.size());
    send_item(8'h5a, 1'b0, 1'b1);
  endtask

  task automatic test_preamble_skip();
    logic [7:0] hdr[$];
    hdr.delete();
    hdr.push_back(8'h00);
    repeat (PREAMBLE_BYTES_DEFAULT - 1) hdr.push_back(8'hff);
    hdr.push_back(MAGIC_ID1);
    hdr.push_back(MAGIC_ID2);
    hdr.push_back(METHOD_DEFL);
    hdr.push_back(8'hdf);
    repeat (8) hdr.push_back(8'hff);
    hdr.push_back(8'h02);
    hdr.push_back(8'h00);
    hdr.push_back(8'h00);
    hdr.push_back(8'h80);
    hdr.push_back(8'h61);
    hdr.push_back(8'h00);
    hdr.push_back(8'h00);
    send_stream(hdr, 0, hdr.size());
  endtask

  task automatic test_random_streams(input int unsigned n_items);
    logic [7:0] hdr[$];
    int unsigned sent;
    int unsigned kind;
    int unsigned cut;
    int unsigned base;
    int unsigned tail;
    bit pre;
    sent = 0;
    while (sent < n_items) begin
      pre = ($urandom_range(59) == 0);
      build_header(hdr, pre);
      base = pre ? PREAMBLE_BYTES_DEFAULT : 0;
      kind = $urandom_range(99);
      if (kind < 70) begin
        send_stream(hdr, 0, hdr.size());
        sent += hdr.size();
      end else if (kind < 78) begin
        // end of input partway through the header
        cut = $urandom_range(hdr.size() - 1, 1);
        send_stream(hdr, 0, cut);
        send_item(8'($urandom), 1'b0, 1'b1);
        sent += cut + 1;
      end else if (kind < 86) begin
        hdr[base + $urandom_range(3)] = 8'($urandom);
        send_stream(hdr, 0, hdr.size());
        sent += hdr.size();
      end else if (kind < 91) begin
        hdr[base + 3][FB_ENC + 1] = 1'b1;
        send_stream(hdr, 0, hdr.size());
        sent += hdr.size();
      end else if (kind < 96) begin
        // cut off and restarted by the next stream
        cut = $urandom_range(hdr.size() - 1, 1);
        send_stream(hdr, 0, cut);
        sent += cut;
      end else begin
        send_item(8'($urandom), 1'b1, 1'b1);
        sent++;
      end
      tail = $urandom_range(2);
      repeat (tail) send_item(8'($urandom), 1'b0, $urandom_range(3) == 0);
      sent += tail;
    end
  endtask

  task automatic test_output_hold();
    logic [7:0] hdr[$];
    hold_len = 300;
    hold_req++;
    repeat (3) begin
      build_header(hdr, 1'b0);
      send_stream(hdr, 0, hdr.size());
    end
    drain_results();
  endtask

  task automatic test_sender_pause();
    logic [7:0] hdr[$];
    build_header(hdr, 1'b0);
    send_stream(hdr, 0, 5);
    drain_results();
    send_stream(hdr, 5, hdr.size());
    drain_results();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    tx_idle_pct = 7;
    rx_idle_pct = 61;
    test_idle_after_reset();
    test_header_errors();
    test_preamble_skip();
    test_random_streams(550);
    tx_idle_pct = 61;
    rx_idle_pct = 7;
    test_random_streams(550);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_output_hold();
    test_sender_pause();
    test_random_streams(550);
    drain_results();
    repeat (8) @(posedge clk);
    $display("checked %0d results: %0d headers done, %0d rejected, %0d truncated",
             checked_count, done_count, reject_count, trunc_count);
    $display("random and directed streams ran under three idle mixes with a long output hold");
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
